>>> rtl/core/cpc_pkg.sv
package cpc_pkg;

  // Internal angle: 2^32 units make one full turn, wrapping
  localparam int unsigned ZW = 32;
  localparam logic [ZW-1:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [ZW-1:0] HALF_TURN          = 32'h8000_0000;
  localparam logic [ZW-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // Fraction bits carried through the rotation datapath
  localparam int unsigned GUARD_BITS = 16;

  // CORDIC limit gain 0.60725293... in Q0.32
  localparam int unsigned GAIN_W    = 32;
  localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'h9B74_EDA8;
  localparam int unsigned PRE_SHIFT = GAIN_W - GUARD_BITS;

  // Size of the arctangent table
  localparam int unsigned MAX_STEPS = 32;
  localparam int unsigned TAB_W     = $clog2(MAX_STEPS);

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_CART  = 1'b1
  } op_e;

  // Per-item control from the classifier to the rotation pipeline
  typedef struct packed {
    op_e  op;
    logic bypass;   // result already known, rotations pass it through
    logic a_neg;    // negate the scaled first operand
    logic b_neg;    // negate the scaled second operand
  } ctl_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [ZW-1:0] atan_units(input logic [TAB_W-1:0] idx);
    logic [ZW-1:0] val;
    case (idx)
      5'd0:  val = 32'h2000_0000;
      5'd1:  val = 32'h12E4_051E;
      5'd2:  val = 32'h09FB_385B;
      5'd3:  val = 32'h0511_11D4;
      5'd4:  val = 32'h028B_0D43;
      5'd5:  val = 32'h0145_D7E1;
      5'd6:  val = 32'h00A2_F61E;
      5'd7:  val = 32'h0051_7C55;
      5'd8:  val = 32'h0028_BE53;
      5'd9:  val = 32'h0014_5F2F;
      5'd10: val = 32'h000A_2F98;
      5'd11: val = 32'h0005_17CC;
      5'd12: val = 32'h0002_8BE6;
      5'd13: val = 32'h0001_45F3;
      5'd14: val = 32'h0000_A2FA;
      5'd15: val = 32'h0000_517D;
      5'd16: val = 32'h0000_28BE;
      5'd17: val = 32'h0000_145F;
      5'd18: val = 32'h0000_0A30;
      5'd19: val = 32'h0000_0518;
      5'd20: val = 32'h0000_028C;
      5'd21: val = 32'h0000_0146;
      5'd22: val = 32'h0000_00A3;
      5'd23: val = 32'h0000_0051;
      5'd24: val = 32'h0000_0029;
      5'd25: val = 32'h0000_0014;
      5'd26: val = 32'h0000_000A;
      5'd27: val = 32'h0000_0005;
      5'd28: val = 32'h0000_0003;
      5'd29: val = 32'h0000_0001;
      5'd30: val = 32'h0000_0001;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/cpc_if.sv
// Input channel: one point to convert
interface cpc_in_if #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic        [COORD_WIDTH-2:0] radius_in;
  logic        [ANGLE_WIDTH-1:0] angle_in;

  modport source (
    output valid, operation, x_in, y_in, radius_in, angle_in,
    input  ready
  );
  modport sink (
    input  valid, operation, x_in, y_in, radius_in, angle_in,
    output ready
  );
endinterface

// Output channel: one converted point
interface cpc_out_if #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic        [COORD_WIDTH-1:0] radius_out;
  logic        [ANGLE_WIDTH-1:0] angle_out;

  modport source (
    output valid, x_out, y_out, radius_out, angle_out,
    input  ready
  );
  modport sink (
    input  valid, x_out, y_out, radius_out, angle_out,
    output ready
  );
endinterface

>>> rtl/core/cpc_queue.sv
module cpc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue push without pop did not add an entry");

endmodule

>>> rtl/core/cpc_front.sv
module cpc_front #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cpc_in_if.sink                    in_i,
  output logic                      item_valid_o,
  input  logic                      item_ready_i,
  output cpc_pkg::ctl_t             item_ctl_o,
  output logic [COORD_WIDTH-1:0]    item_a_o,
  output logic [COORD_WIDTH-1:0]    item_b_o,
  output logic [cpc_pkg::ZW-1:0]    item_z_o
);

  import cpc_pkg::*;

  logic                   x_neg, y_neg, x_zero, y_zero, far;
  logic [COORD_WIDTH-1:0] abs_x, abs_y;
  logic [ZW-1:0]          z_cart, z_turn;

  ctl_t                   ctl_d, ctl_q;
  logic [COORD_WIDTH-1:0] a_d, a_q, b_d, b_q;
  logic [ZW-1:0]          z_d, z_q;
  logic                   valid_q;

  // Sign, zero and magnitude of the Cartesian point
  assign x_neg  = in_i.x_in[COORD_WIDTH-1];
  assign y_neg  = in_i.y_in[COORD_WIDTH-1];
  assign x_zero = (in_i.x_in == '0);
  assign y_zero = (in_i.y_in == '0);
  assign abs_x  = x_neg ? -in_i.x_in : in_i.x_in;
  assign abs_y  = y_neg ? -in_i.y_in : in_i.y_in;

  // Polar angle in full-turn units; far half gets folded by a half turn
  assign z_cart = ZW'(in_i.angle_in) << (ZW - ANGLE_WIDTH);
  assign z_turn = z_cart + QUARTER_TURN;
  assign far    = z_turn[ZW-1];

  // Classify: for the to-polar direction, axis and zero points are resolved here and bypass rotation
  always_comb begin
    ctl_d.op     = op_e'(in_i.operation);
    ctl_d.bypass = 1'b0;
    ctl_d.a_neg  = 1'b0;
    ctl_d.b_neg  = 1'b0;
    a_d          = '0;
    b_d          = '0;
    z_d          = '0;
    if (ctl_d.op == OP_TO_CART) begin
      a_d         = COORD_WIDTH'(in_i.radius_in);
      ctl_d.a_neg = far;
      z_d         = far ? z_cart - HALF_TURN : z_cart;
    end else if (x_zero && y_zero) begin
      ctl_d.bypass = 1'b1;
    end else if (y_zero) begin
      ctl_d.bypass = 1'b1;
      a_d          = abs_x;
      z_d          = x_neg ? HALF_TURN : '0;
    end else if (x_zero) begin
      ctl_d.bypass = 1'b1;
      a_d          = abs_y;
      z_d          = y_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
    end else begin
      // left half plane: start from the mirrored point plus a half turn
      a_d         = abs_x;
      b_d         = abs_y;
      ctl_d.b_neg = x_neg ^ y_neg;
      z_d         = x_neg ? HALF_TURN : '0;
    end
  end

  // Item register in front of the queue
  assign in_i.ready = !valid_q || item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ctl_q <= ctl_d;
      a_q   <= a_d;
      b_q   <= b_d;
      z_q   <= z_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_ctl_o   = ctl_q;
  assign item_a_o     = a_q;
  assign item_b_o     = b_q;
  assign item_z_o     = z_q;

endmodule

>>> rtl/core/cpc_back.sv
module cpc_back #(
  parameter int unsigned COORD_WIDTH    = 16,
  parameter int unsigned ANGLE_WIDTH    = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  cpc_pkg::ctl_t          item_ctl_i,
  input  logic [COORD_WIDTH-1:0] item_a_i,
  input  logic [COORD_WIDTH-1:0] item_b_i,
  input  logic [cpc_pkg::ZW-1:0] item_z_i,
  cpc_out_if.source              out_o
);

  import cpc_pkg::*;

  localparam int unsigned S       = ROTATION_STEPS;
  localparam int unsigned W       = COORD_WIDTH + GUARD_BITS + 2;
  localparam int unsigned PROD_W  = COORD_WIDTH + GAIN_W;
  localparam int unsigned RW      = W - GUARD_BITS;
  localparam int unsigned ANG_SH  = ZW - ANGLE_WIDTH;
  localparam logic [PROD_W-1:0]   PRE_RND = PROD_W'(1) << (PRE_SHIFT - 1);
  localparam logic signed [W-1:0] OUT_RND = W'(1) << (GUARD_BITS - 1);
  localparam logic [ZW-1:0]       ANG_RND = (ANG_SH > 0) ? (ZW'(1) << (ANG_SH - 1)) : '0;
  localparam logic signed [RW-1:0] COORD_LIM = RW'({(COORD_WIDTH - 1){1'b1}});
  localparam logic signed [RW-1:0] RAD_MAX   = RW'({COORD_WIDTH{1'b1}});

  logic                     en;
  logic [S:0]               valid_q;
  ctl_t                     ctl_q [S+1];
  logic signed [W-1:0]      cx_q  [S+1];
  logic signed [W-1:0]      cy_q  [S+1];
  logic [ZW-1:0]            z_q   [S+1];
  logic signed [W-1:0]      cx_n  [S];
  logic signed [W-1:0]      cy_n  [S];
  logic [ZW-1:0]            z_n   [S];

  logic [PROD_W-1:0]        prod_a, prod_b;
  logic signed [W-1:0]      pa_s, pb_s, byp_s, cx0, cy0;

  logic signed [W-1:0]      cx_r, cy_r;
  logic signed [RW-1:0]     rx, ry;
  logic [ZW-1:0]            za;
  logic signed [COORD_WIDTH-1:0] x_sat, y_sat;
  logic [COORD_WIDTH-1:0]   rad;
  logic                     out_valid_q;
  logic signed [COORD_WIDTH-1:0] x_q, y_q;
  logic [COORD_WIDTH-1:0]   radius_q;
  logic [ANGLE_WIDTH-1:0]   angle_q;

  // Whole pipeline advances unless a finished item waits at the output
  assign en           = !out_valid_q || out_o.ready;
  assign item_ready_o = en;

  // Gain removal for rotated items: magnitude times K, rounded half up, sign applied after
  assign prod_a = PROD_W'(item_a_i) * PROD_W'(GAIN_Q32) + PRE_RND;
  assign prod_b = PROD_W'(item_b_i) * PROD_W'(GAIN_Q32) + PRE_RND;
  assign pa_s   = signed'(W'(prod_a[PROD_W-1:PRE_SHIFT]));
  assign pb_s   = signed'(W'(prod_b[PROD_W-1:PRE_SHIFT]));
  assign byp_s  = signed'(W'(item_a_i) << GUARD_BITS);
  assign cx0    = item_ctl_i.bypass ? byp_s : (item_ctl_i.a_neg ? -pa_s : pa_s);
  assign cy0    = item_ctl_i.bypass ? '0    : (item_ctl_i.b_neg ? -pb_s : pb_s);

  // One micro-rotation per stage
  for (genvar i = 0; i < S; i++) begin : g_step
    logic signed [W-1:0] dx, dy;
    logic                ccw;
    logic [ZW-1:0]       atan_i;

    assign dx     = cy_q[i] >>> i;
    assign dy     = cx_q[i] >>> i;
    assign atan_i = atan_units(TAB_W'(i));
    // vectoring drives y to zero, rotation drives the residual angle to zero
    assign ccw    = (ctl_q[i].op == OP_TO_POLAR) ? cy_q[i][W-1] : !z_q[i][ZW-1];

    always_comb begin
      if (ctl_q[i].bypass) begin
        cx_n[i] = cx_q[i];
        cy_n[i] = cy_q[i];
        z_n[i]  = z_q[i];
      end else if (ccw) begin
        cx_n[i] = cx_q[i] - dx;
        cy_n[i] = cy_q[i] + dy;
        z_n[i]  = z_q[i] - atan_i;
      end else begin
        cx_n[i] = cx_q[i] + dx;
        cy_n[i] = cy_q[i] - dy;
        z_n[i]  = z_q[i] + atan_i;
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[S-1:0], item_valid_i};
      out_valid_q <= valid_q[S];
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= item_ctl_i;
      cx_q[0]  <= cx0;
      cy_q[0]  <= cy0;
      z_q[0]   <= item_z_i;
      for (int k = 0; k < S; k++) begin
        ctl_q[k+1] <= ctl_q[k];
        cx_q[k+1]  <= cx_n[k];
        cy_q[k+1]  <= cy_n[k];
        z_q[k+1]   <= z_n[k];
      end
    end
  end

  // Output rounding, saturation and angle reduction
  assign cx_r = cx_q[S] + OUT_RND;
  assign cy_r = cy_q[S] + OUT_RND;
  assign rx   = signed'(cx_r[W-1:GUARD_BITS]);
  assign ry   = signed'(cy_r[W-1:GUARD_BITS]);
  assign za   = z_q[S] + ANG_RND;

  always_comb begin
    if (rx > COORD_LIM) begin
      x_sat = COORD_WIDTH'(COORD_LIM);
    end else if (rx < -COORD_LIM) begin
      x_sat = COORD_WIDTH'(-COORD_LIM);
    end else begin
      x_sat = COORD_WIDTH'(rx);
    end
    if (ry > COORD_LIM) begin
      y_sat = COORD_WIDTH'(COORD_LIM);
    end else if (ry < -COORD_LIM) begin
      y_sat = COORD_WIDTH'(-COORD_LIM);
    end else begin
      y_sat = COORD_WIDTH'(ry);
    end
    if (rx < 0) begin
      rad = '0;
    end else if (rx > RAD_MAX) begin
      rad = '1;
    end else begin
      rad = COORD_WIDTH'(rx);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctl_q[S].op == OP_TO_POLAR) begin
        x_q      <= '0;
        y_q      <= '0;
        radius_q <= rad;
        angle_q  <= za[ANG_SH +: ANGLE_WIDTH];
      end else begin
        x_q      <= x_sat;
        y_q      <= y_sat;
        radius_q <= '0;
        angle_q  <= '0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.x_out      = x_q;
  assign out_o.y_out      = y_q;
  assign out_o.radius_out = radius_q;
  assign out_o.angle_out  = angle_q;

  a_pop_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_o |=> valid_q[0])
    else $error("popped item did not enter the first stage");

  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(valid_q))
    else $error("pipeline moved while the output was held");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (x_q != '0 || y_q != '0) |-> radius_q == '0 && angle_q == '0)
    else $error("Cartesian result carries polar fields");

endmodule

>>> rtl/core/cartesian_polar_converter_top.sv
// Channel  Dir  Payload                                   Handshake
// in_i     in   operation, x_in, y_in, radius_in, angle_in valid/ready
// out_o    out  x_out, y_out, radius_out, angle_out       valid/ready
//
// One item per cycle sustained while the output takes results; each item is
// independent of the others. From the accepting edge an item passes the input
// register, the queue, the gain multiply, one stage per micro-rotation and the
// output register.
// Reset clears all valid bits and queue pointers; no payload is reset.
// The input side keeps taking items while a result waits at the output,
// until the two-entry queue and the input register fill up.
module cartesian_polar_converter_top #(
  parameter int unsigned COORD_WIDTH    = 16,
  parameter int unsigned ANGLE_WIDTH    = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpc_in_if.sink     in_i,
  cpc_out_if.source  out_o
);

  import cpc_pkg::*;

  localparam int unsigned CTL_W  = $bits(ctl_t);
  localparam int unsigned ITEM_W = CTL_W + 2 * COORD_WIDTH + ZW;

  logic                   f_valid, f_ready, b_valid, b_ready;
  ctl_t                   f_ctl, b_ctl;
  logic [COORD_WIDTH-1:0] f_a, f_b, b_a, b_b;
  logic [ZW-1:0]          f_z, b_z;
  logic [ITEM_W-1:0]      q_push, q_pop;

  // Accept and classify
  cpc_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_ctl_o   (f_ctl),
    .item_a_o     (f_a),
    .item_b_o     (f_b),
    .item_z_o     (f_z)
  );

  // Decoupling queue
  assign q_push = {f_ctl, f_a, f_b, f_z};
  assign {b_ctl, b_a, b_b, b_z} = q_pop;

  cpc_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_push),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_pop)
  );

  // Rotation pipeline and output register
  cpc_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .ANGLE_WIDTH    (ANGLE_WIDTH),
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_ctl_i   (b_ctl),
    .item_a_i     (b_a),
    .item_b_i     (b_b),
    .item_z_i     (b_z),
    .out_o        (out_o)
  );

endmodule

>>> dv/cpc_checker.sv
// Watches both channels of the converter, predicts every converted point
// and compares it with what the block hands out, in order.
module cpc_checker #(
  parameter int unsigned COORD_WIDTH    = 16,
  parameter int unsigned ANGLE_WIDTH    = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  cpc_in_if    in_ch_i,
  cpc_out_if   out_ch_i,
  output int   mismatch_o,
  output int   pending_o
);

  import cpc_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned AW = ANGLE_WIDTH;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [16] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic        [CW-1:0] radius;
    logic        [AW-1:0] angle;
  } point_res_t;

  point_res_t converted_q[$];

  // Magnitude times the inverse gain, rounded half up, sign put back after
  function automatic longint gain_scale(input longint v);
    longint unsigned mag;
    longint unsigned p;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    p = (mag * 64'(GAIN_Q32) + (64'd1 << (31 - GUARD_BITS))) >> (32 - GUARD_BITS);
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint round_fix(input longint v);
    return (v + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
  endfunction

  // 32-bit turn fraction rounded to the output angle width, wrapping
  function automatic logic [AW-1:0] angle_code(input logic [31:0] z);
    logic [32:0] s;
    s = {1'b0, z} + (33'd1 << (31 - AW));
    return AW'(s >> (32 - AW));
  endfunction

  function automatic logic signed [CW-1:0] coord_sat(input longint v);
    longint r;
    longint lim;
    lim = (longint'(1) << (CW - 1)) - 1;
    r = round_fix(v);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[CW-1:0];
  endfunction

  // Expected result of one point, either direction
  function automatic point_res_t cordic_convert(
    input logic                 op,
    input logic signed [CW-1:0] x,
    input logic signed [CW-1:0] y,
    input logic        [CW-2:0] rad,
    input logic        [AW-1:0] ang
  );
    point_res_t  res;
    longint      xs, ys, cx, cy, dx, dy, r;
    logic [31:0] z, t;
    res = '0;
    xs  = longint'(x);
    ys  = longint'(y);
    if (op == OP_TO_POLAR) begin
      if (xs == 0 && ys == 0) begin
        res.radius = '0;
        res.angle  = '0;
      end else if (ys == 0) begin
        // on the x axis: exact magnitude
        res.radius = CW'((xs < 0) ? -xs : xs);
        res.angle  = angle_code((xs > 0) ? 32'd0 : HALF_TURN);
      end else if (xs == 0) begin
        res.radius = CW'((ys < 0) ? -ys : ys);
        res.angle  = angle_code((ys > 0) ? QUARTER_TURN : THREE_QUARTER_TURN);
      end else begin
        cx = gain_scale(xs);
        cy = gain_scale(ys);
        z  = '0;
        // left half plane: flip and start from a half turn
        if (cx < 0) begin
          cx = -cx;
          cy = -cy;
          z  = HALF_TURN;
        end
        for (int i = 0; i < int'(ROTATION_STEPS); i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy < 0) begin
            cx = cx - dx;
            cy = cy + dy;
            z  = z - ATAN_TAB[i];
          end else begin
            cx = cx + dx;
            cy = cy - dy;
            z  = z + ATAN_TAB[i];
          end
        end
        r = round_fix(cx);
        if (r < 0) r = 0;
        if (r > (longint'(1) << CW) - 1) r = (longint'(1) << CW) - 1;
        res.radius = r[CW-1:0];
        res.angle  = angle_code(z);
      end
    end else begin
      cx = gain_scale(longint'(rad));
      cy = 0;
      z  = 32'(ang) << (32 - AW);
      // far angles: rotate the start vector by a half turn
      t = z + QUARTER_TURN;
      if (t[31]) begin
        cx = -cx;
        z  = z - HALF_TURN;
      end
      for (int i = 0; i < int'(ROTATION_STEPS); i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z[31]) begin
          cx = cx + dx;
          cy = cy - dy;
          z  = z + ATAN_TAB[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z  = z - ATAN_TAB[i];
        end
      end
      res.x = coord_sat(cx);
      res.y = coord_sat(cy);
    end
    return res;
  endfunction

  function automatic int field_check(input string name, input longint want,
                                     input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare finished points, then record newly accepted ones
  always @(posedge clk_i) begin : watch
    point_res_t got_res;
    point_res_t want;
    int         nbad;
    if (!rst_ni) begin
      mismatch_o <= 0;
      pending_o  <= 0;
    end else begin
      nbad = 0;
      if (out_ch_i.valid && out_ch_i.ready) begin
        got_res.x      = out_ch_i.x_out;
        got_res.y      = out_ch_i.y_out;
        got_res.radius = out_ch_i.radius_out;
        got_res.angle  = out_ch_i.angle_out;
        if (converted_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual x %0d y %0d r %0d a %0d",
                   $time, got_res.x, got_res.y, got_res.radius, got_res.angle);
          nbad = 1;
        end else begin
          want = converted_q.pop_front();
          nbad += field_check("x_out", longint'(want.x), longint'(got_res.x));
          nbad += field_check("y_out", longint'(want.y), longint'(got_res.y));
          nbad += field_check("radius_out", longint'(want.radius),
                              longint'(got_res.radius));
          nbad += field_check("angle_out", longint'(want.angle),
                              longint'(got_res.angle));
          if (nbad > 0) nbad = 1;
        end
      end
      if (in_ch_i.valid && in_ch_i.ready) begin
        converted_q.insert(converted_q.size(),
                           cordic_convert(in_ch_i.operation, in_ch_i.x_in,
                                          in_ch_i.y_in, in_ch_i.radius_in,
                                          in_ch_i.angle_in));
      end
      mismatch_o <= mismatch_o + nbad;
      pending_o  <= converted_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
module testbench;
  import cpc_pkg::*;

  localparam int unsigned CW      = 16;
  localparam int unsigned AW      = 16;
  localparam int unsigned STEPS   = 16;
  localparam int unsigned LATENCY = STEPS + 4;
  localparam int          N_RAND  = 1950;

  logic clk_i;
  logic rst_ni;
  int   mismatch_cnt;
  int   pending_cnt;

  cpc_in_if  #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) in_ch ();
  cpc_out_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) out_ch ();

  cartesian_polar_converter_top #(
    .COORD_WIDTH   (CW),
    .ANGLE_WIDTH   (AW),
    .ROTATION_STEPS(STEPS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  cpc_checker #(
    .COORD_WIDTH   (CW),
    .ANGLE_WIDTH   (AW),
    .ROTATION_STEPS(STEPS)
  ) chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch),
    .out_ch_i  (out_ch),
    .mismatch_o(mismatch_cnt),
    .pending_o (pending_cnt)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Hard stop
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Offer one point after a gap; returns on the falling edge after acceptance
  task automatic push_point(input op_e op, input int x, input int y, input int r,
                            input int a, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.x_in      <= CW'(x);
    in_ch.y_in      <= CW'(y);
    in_ch.radius_in <= (CW-1)'(r);
    in_ch.angle_in  <= AW'(a);
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Coordinates leaning on axes, extremes and small values
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($signed(16'($urandom)));
      4:          return int'($urandom_range(0, 16)) - 8;
      5:          return 0;
      6: begin
        case ($urandom_range(0, 4))
          0:       return -32768;
          1:       return -32767;
          2:       return 32767;
          3:       return -1;
          default: return 1;
        endcase
      end
      default:    return int'($urandom_range(0, 511)) - 256;
    endcase
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 32767));
      6:                return int'($urandom_range(0, 15));
      7:                return 32767;
      default:          return int'($urandom_range(0, 2047));
    endcase
  endfunction

  // Angles near quadrant boundaries a quarter of the time
  function automatic int pick_angle();
    if ($urandom_range(0, 3) == 0)
      return int'($urandom_range(0, 3) << 14) + int'($urandom_range(0, 4)) - 2;
    return int'($urandom_range(0, 65535));
  endfunction

  // Receiver: random stalls, bursts with none, one long hold-off
  initial begin : sink_side
    int  got;
    int  w;
    bit  burst;
    got   = 0;
    burst = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (got % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      w = burst ? 0 : int'($urandom_range(0, 11));
      if (got == 600) w = 400;
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got++;
      @(negedge clk_i);
    end
  end

  // Reset, stimulus and verdict
  initial begin : source_side
    int  gap;
    bit  burst;
    op_e op;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_TO_POLAR;
    in_ch.x_in      <= '0;
    in_ch.y_in      <= '0;
    in_ch.radius_in <= '0;
    in_ch.angle_in  <= '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero point, axes, extremes, each quadrant, then to-Cartesian points at and near quadrant angles
    push_point(OP_TO_POLAR, 0, 0, pick_radius(), pick_angle(), 0);
    push_point(OP_TO_POLAR, 100, 0, pick_radius(), pick_angle(), $urandom_range(0, 11));
    push_point(OP_TO_POLAR, -100, 0, pick_radius(), pick_angle(), 0);
    push_point(OP_TO_POLAR, 0, 100, pick_radius(), pick_angle(), $urandom_range(0, 11));
    push_point(OP_TO_POLAR, 0, -100, pick_radius(), pick_angle(), 0);
    push_point(OP_TO_POLAR, 32767, 0, 0, 0, 0);
    push_point(OP_TO_POLAR, -32768, 0, 32767, 65535, 0);
    push_point(OP_TO_POLAR, 0, -32768, 0, 0, $urandom_range(0, 11));
    push_point(OP_TO_POLAR, 0, 32767, 0, 0, 0);
    push_point(OP_TO_POLAR, 32767, 32767, 0, 0, 0);
    push_point(OP_TO_POLAR, -32768, -32768, 0, 0, 0);
    push_point(OP_TO_POLAR, -32768, 32767, 0, 0, 0);
    push_point(OP_TO_POLAR, 32767, -32768, 0, 0, $urandom_range(0, 11));
    push_point(OP_TO_POLAR, 1, 1, 0, 0, 0);
    push_point(OP_TO_POLAR, -1, -1, 0, 0, 0);
    push_point(OP_TO_POLAR, 1, -1, 0, 0, 0);
    push_point(OP_TO_POLAR, -1, 1, 0, 0, 0);
    push_point(OP_TO_CART, pick_coord(), pick_coord(), 0, 0, 0);
    push_point(OP_TO_CART, -32768, 32767, 32767, 0, $urandom_range(0, 11));
    push_point(OP_TO_CART, 32767, -32768, 32767, 16'h4000, 0);
    push_point(OP_TO_CART, 0, 0, 32767, 16'h8000, 0);
    push_point(OP_TO_CART, 0, 0, 32767, 16'hC000, 0);
    push_point(OP_TO_CART, 0, 0, 32767, 16'hFFFF, 0);
    push_point(OP_TO_CART, 0, 0, 32767, 16'h3FFF, 0);
    push_point(OP_TO_CART, 0, 0, 32767, 16'h2000, 0);
    push_point(OP_TO_CART, 0, 0, 1, 16'h6000, 0);

    // Random points, gaps in some stretches and none in others
    burst = 1'b0;
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : int'($urandom_range(0, 11));
      op  = op_e'($urandom_range(0, 1));
      push_point(op, pick_coord(), pick_coord(), pick_radius(), pick_angle(), gap);
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray items
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (3 * LATENCY) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
